@@ design/set_assoc_cache_lru_directory_macros.svh @@
`ifndef SET_ASSOC_CACHE_LRU_DIRECTORY_MACROS_SVH
`define SET_ASSOC_CACHE_LRU_DIRECTORY_MACROS_SVH

// same-cycle implication, disabled during reset
`define SALRU_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define SALRU_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// delayed implication, disabled during reset
`define SALRU_ASSERT_LATER(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

@@ design/salru_pkg.sv @@
`default_nettype none
package salru_pkg;

  localparam int WAYS       = 2;
  localparam int SETS       = 8;
  localparam int LINE_BYTES = 64;
  localparam int ADDR_BITS  = 16;

  localparam int OFF_BITS = $clog2(LINE_BYTES);
  localparam int IDX_BITS = $clog2(SETS);
  localparam int TAG_BITS = ADDR_BITS - OFF_BITS - IDX_BITS;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int AGE_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * TAG_BITS;

  localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(WAYS - 1);

  typedef struct packed {
    logic                 action;
    logic [ADDR_BITS-1:0] address;
  } request_t;

  typedef struct packed {
    logic                hit;
    logic                misaligned;
    logic [IDX_BITS-1:0] set_index;
    logic [TAG_BITS-1:0] tag_value;
    logic [WAY_W-1:0]    way_used;
    logic                evicted;
    logic [TAG_BITS-1:0] evicted_tag;
    logic                memory_write;
  } result_t;

  typedef struct packed {
    logic capture;
    logic update;
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

endpackage
`default_nettype wire

@@ design/salru_ctrl.sv @@
`default_nettype none
module salru_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  output salru_pkg::cmd_t  cmd
);

  salru_pkg::state_t state;
  salru_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= salru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      salru_pkg::ST_IDLE: begin
        if (start) state_next = salru_pkg::ST_UPDATE;
      end
      salru_pkg::ST_UPDATE: begin
        state_next = salru_pkg::ST_IDLE;
      end
      default: state_next = salru_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    busy        = 1'b0;
    cmd.capture = 1'b0;
    cmd.update  = 1'b0;
    unique case (state)
      salru_pkg::ST_IDLE: begin
        cmd.capture = start;
      end
      salru_pkg::ST_UPDATE: begin
        busy       = 1'b1;
        cmd.update = 1'b1;
      end
      default: begin
        busy = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

@@ design/salru_datapath.sv @@
`default_nettype none
module salru_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire salru_pkg::cmd_t     cmd,
  input  wire salru_pkg::request_t request,
  output logic                     done,
  output salru_pkg::result_t       result
);

  localparam int TW = salru_pkg::TAG_BITS;
  localparam int IW = salru_pkg::IDX_BITS;
  localparam int OW = salru_pkg::OFF_BITS;

  logic [salru_pkg::ROW_W-1:0] tag_mem [salru_pkg::SETS];
  logic [salru_pkg::ROW_W-1:0] row;

  logic [salru_pkg::WAYS-1:0]  valid [salru_pkg::SETS];
  logic [salru_pkg::AGE_W-1:0] age   [salru_pkg::SETS][salru_pkg::WAYS];

  salru_pkg::request_t req;

  logic [IW-1:0]                  set_sel;
  logic [TW-1:0]                  tag_sel;
  logic                           misaligned;
  logic [salru_pkg::WAYS-1:0]     match;
  logic                           hit;
  logic [salru_pkg::WAY_W-1:0]    hit_way;
  logic                           found;
  logic [salru_pkg::WAY_W-1:0]    free_way;
  logic [salru_pkg::WAY_W-1:0]    old_way;
  logic [salru_pkg::AGE_W-1:0]    best;
  logic [salru_pkg::WAY_W-1:0]    way;
  logic                           evict;
  logic [TW-1:0]                  evict_tag;
  logic [salru_pkg::AGE_W-1:0]    hit_age;
  logic [salru_pkg::AGE_W-1:0]    age_next [salru_pkg::WAYS];
  logic [salru_pkg::WAYS-1:0]     valid_next;
  logic [salru_pkg::ROW_W-1:0]    row_next;
  logic                           wr_en;

  always_comb begin
    set_sel    = req.address[OW +: IW];
    tag_sel    = req.address[OW + IW +: TW];
    misaligned = |req.address[1:0];

    for (int w = 0; w < salru_pkg::WAYS; w++) begin
      match[w] = valid[set_sel][w] && (row[w*TW +: TW] == tag_sel);
    end

    hit     = 1'b0;
    hit_way = '0;
    found    = 1'b0;
    free_way = '0;
    for (int w = salru_pkg::WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit     = 1'b1;
        hit_way = salru_pkg::WAY_W'(w);
      end
      if (!valid[set_sel][w]) begin
        found    = 1'b1;
        free_way = salru_pkg::WAY_W'(w);
      end
    end

    best    = '0;
    old_way = '0;
    for (int w = 0; w < salru_pkg::WAYS; w++) begin
      if (age[set_sel][w] > best) begin
        best    = age[set_sel][w];
        old_way = salru_pkg::WAY_W'(w);
      end
    end

    way       = hit ? hit_way : (found ? free_way : old_way);
    evict     = !hit && !found;
    evict_tag = evict ? row[way*TW +: TW] : '0;
    hit_age   = age[set_sel][hit_way];

    valid_next = valid[set_sel];
    row_next   = row;
    for (int w = 0; w < salru_pkg::WAYS; w++) begin
      age_next[w] = age[set_sel][w];
      if (salru_pkg::WAY_W'(w) == way) begin
        age_next[w] = '0;
      end else if (hit) begin
        if (age[set_sel][w] < hit_age) age_next[w] = age[set_sel][w] + 1'b1;
      end else begin
        if (age[set_sel][w] < salru_pkg::AGE_MAX) age_next[w] = age[set_sel][w] + 1'b1;
      end
    end
    if (!hit) begin
      valid_next[way]      = 1'b1;
      row_next[way*TW +: TW] = tag_sel;
    end

    wr_en = cmd.update && !misaligned;
  end

  // capture the request and read the set's tag row
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= request;
      row <= tag_mem[request.address[OW +: IW]];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en && !hit) begin
      tag_mem[set_sel] <= row_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < salru_pkg::SETS; s++) begin
        valid[s] <= '0;
        for (int w = 0; w < salru_pkg::WAYS; w++) age[s][w] <= '0;
      end
    end else if (wr_en) begin
      valid[set_sel] <= valid_next;
      for (int w = 0; w < salru_pkg::WAYS; w++) age[set_sel][w] <= age_next[w];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.update;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result.set_index  <= set_sel;
      result.tag_value  <= tag_sel;
      result.misaligned <= misaligned;
      if (misaligned) begin
        result.hit          <= 1'b0;
        result.way_used     <= '0;
        result.evicted      <= 1'b0;
        result.evicted_tag  <= '0;
        result.memory_write <= 1'b0;
      end else begin
        result.hit          <= hit;
        result.way_used     <= way;
        result.evicted      <= evict;
        result.evicted_tag  <= evict_tag;
        result.memory_write <= req.action;
      end
    end
  end

endmodule
`default_nettype wire

@@ design/set_assoc_cache_lru_directory.sv @@
`default_nettype none
// Tag directory of a 2-way set-associative write-through cache with LRU
// replacement. An access is taken when start is high and busy is low; the
// set's tag row is read from a registered tag memory on that edge, the next
// cycle compares both ways and, unless the address is misaligned, updates
// valid, LRU and tag state, and the result appears on the cycle after with
// done high for exactly one cycle. No new access is taken while busy is
// high; a new start may coincide with the done cycle. The receiver cannot
// stall: result is valid only while done is high and must be taken then.
`include "set_assoc_cache_lru_directory_macros.svh"
module set_assoc_cache_lru_directory (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                start,
  output logic                     busy,
  input  wire salru_pkg::request_t request,
  output logic                     done,
  output salru_pkg::result_t       result
);

  salru_pkg::cmd_t cmd;

  salru_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  salru_datapath u_datapath (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .request (request),
    .done    (done),
    .result  (result)
  );

  `SALRU_ASSERT_NOW(a_done_idle, clk, rst, done, !busy, "result strobed while busy")
  `SALRU_ASSERT_NEXT(a_busy_after_start, clk, rst, start && !busy, busy && !done,
                     "transfer did not start")
  `SALRU_ASSERT_LATER(a_result_latency, clk, rst, start && !busy, done,
                      "result missing two cycles on")
  `SALRU_ASSERT_NOW(a_misaligned_quiet, clk, rst, done && result.misaligned,
                    !result.hit && !result.evicted && !result.memory_write,
                    "misaligned access changed outcome")
  `SALRU_ASSERT_NOW(a_hit_no_evict, clk, rst, done && result.hit, !result.evicted,
                    "hit reported an eviction")

endmodule
`default_nettype wire
